>>> src/gaussian_filterbank_bin_weighting_core_defines.svh
// Assertion macros shared by the filter bank bin weighting RTL.
`ifndef GAUSSIAN_FILTERBANK_BIN_WEIGHTING_CORE_DEFINES_SVH
`define GAUSSIAN_FILTERBANK_BIN_WEIGHTING_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define GFBW_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("gfbw same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define GFBW_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("gfbw next-cycle check failed");

`endif

>>> src/gfbw_pkg.sv
// Types, commands and constants of the filter bank bin weighting block.
`default_nettype none
package gfbw_pkg;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PMUL, ST_RD, ST_DSQ, ST_WSQ, ST_CHK, ST_DIV, ST_EXP,
    ST_GAIN, ST_MRE, ST_MIM, ST_EMIT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_PMUL, OP_RD, OP_DSQ, OP_WSQ, OP_CHK, OP_DIV, OP_EXP,
    OP_GAIN, OP_MRE, OP_MIM, OP_EMIT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [3:0] step;
  } cmd_t;

  typedef struct packed {
    logic last;
  } status_t;

  localparam int unsigned XBITS = 12;
  localparam logic [3:0] PMUL_LAST = 4'd3;
  localparam logic [3:0] XSTEP_LAST = 4'(XBITS - 1);

  // exp(-2^(k-8)) in Q0.32
  function automatic logic [31:0] exp_coef(input logic [3:0] k);
    logic [31:0] c;
    case (k)
      4'd0:    c = 32'd4278222805;
      4'd1:    c = 32'd4261543596;
      4'd2:    c = 32'd4228380001;
      4'd3:    c = 32'd4162825044;
      4'd4:    c = 32'd4034748382;
      4'd5:    c = 32'd3790295336;
      4'd6:    c = 32'd3344923893;
      4'd7:    c = 32'd2605029347;
      4'd8:    c = 32'd1580030169;
      4'd9:    c = 32'd581260615;
      4'd10:   c = 32'd78665069;
      4'd11:   c = 32'd1440802;
      default: c = 32'd0;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

>>> src/gfbw_ctrl.sv
// Sequencer that steps one bin through every band in use, one band at a time.
`default_nettype none
module gfbw_ctrl
  import gfbw_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    go,
  input  wire status_t status,
  output cmd_t         cmd,
  output logic         busy
);

  state_t     state_r, state_nxt;
  logic [3:0] step_r, step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= 4'd0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = 4'd0;
    cmd.op    = OP_NONE;
    cmd.step  = step_r;
    case (state_r)
      ST_IDLE: begin
        if (go) state_nxt = ST_PMUL;
      end
      ST_PMUL: begin
        cmd.op = OP_PMUL;
        if (step_r == PMUL_LAST) state_nxt = ST_RD;
        else step_nxt = step_r + 4'd1;
      end
      ST_RD: begin
        cmd.op    = OP_RD;
        state_nxt = ST_DSQ;
      end
      ST_DSQ: begin
        cmd.op    = OP_DSQ;
        state_nxt = ST_WSQ;
      end
      ST_WSQ: begin
        cmd.op    = OP_WSQ;
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        cmd.op    = OP_CHK;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.op = OP_DIV;
        if (step_r == XSTEP_LAST) state_nxt = ST_EXP;
        else step_nxt = step_r + 4'd1;
      end
      ST_EXP: begin
        cmd.op = OP_EXP;
        if (step_r == XSTEP_LAST) state_nxt = ST_GAIN;
        else step_nxt = step_r + 4'd1;
      end
      ST_GAIN: begin
        cmd.op    = OP_GAIN;
        state_nxt = ST_MRE;
      end
      ST_MRE: begin
        cmd.op    = OP_MRE;
        state_nxt = ST_MIM;
      end
      ST_MIM: begin
        cmd.op    = OP_MIM;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.op    = OP_EMIT;
        state_nxt = status.last ? ST_IDLE : ST_RD;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule
`default_nettype wire

>>> src/gfbw_dp.sv
// Datapath: band table, Gaussian divider and exponent unit, complex scaling.
`default_nettype none
module gfbw_dp
  import gfbw_pkg::*;
#(
  parameter int unsigned MAX_BANDS = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cmd_t               cmd,
  output status_t                 status,
  input  wire logic [6:0]         band_count,
  input  wire logic               load_we,
  input  wire logic               capture,
  input  wire logic [5:0]         in_band_slot,
  input  wire logic [19:0]        in_center_freq,
  input  wire logic [19:0]        in_band_width,
  input  wire logic [19:0]        in_bin_freq,
  input  wire logic               in_dc_bin,
  input  wire logic signed [15:0] in_weight_re,
  input  wire logic signed [15:0] in_weight_im,
  input  wire logic signed [23:0] in_spec_re,
  input  wire logic signed [23:0] in_spec_im,
  output logic                    out_strobe,
  output logic [5:0]              out_band,
  output logic signed [25:0]      out_re,
  output logic signed [25:0]      out_im,
  output logic                    out_last_band
);

  localparam int unsigned AW = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;

  logic [19:0] mem_c [MAX_BANDS];
  logic [19:0] mem_w [MAX_BANDS];

  logic [19:0]        f_r, c_r, w_r;
  logic               dc_r;
  logic signed [15:0] hr_r, hi_r;
  logic signed [23:0] xr_r, xi_r;
  logic signed [40:0] pr_r, pi_r;
  logic [5:0]         idx_r;
  logic [39:0]        d2_r, w2_r;
  logic [46:0]        rem_r;
  logic [50:0]        dv_r;
  logic [11:0]        x_r;
  logic               zero_r, one_r;
  logic [31:0]        acc_r;
  logic [15:0]        g_r;
  logic signed [57:0] pre_r, pim_r;
  logic               strobe_r, last_r;
  logic [5:0]         band_r;
  logic signed [25:0] re_r, im_r;

  // operand select for the item-level products
  logic signed [23:0] ma;
  logic signed [15:0] mb;
  logic signed [39:0] mp;
  logic signed [20:0] dd;
  logic [19:0]        ad;
  logic               ge;
  logic [31:0]        coef;
  logic [63:0]        ep, er;
  logic [32:0]        ga;
  logic [16:0]        gs;
  logic [15:0]        gq;
  logic signed [16:0] gsg;
  logic signed [57:0] pm;
  logic [6:0]         n_eff;
  logic               wr_ok;

  assign wr_ok = load_we && ({1'b0, in_band_slot} < 7'(MAX_BANDS));

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem_c[in_band_slot[AW-1:0]] <= in_center_freq;
      mem_w[in_band_slot[AW-1:0]] <= in_band_width;
    end
    if (cmd.op == OP_RD) begin
      c_r <= mem_c[idx_r[AW-1:0]];
      w_r <= mem_w[idx_r[AW-1:0]];
    end
  end

  always_comb begin
    if (band_count == 7'd0) n_eff = 7'd1;
    else if (band_count > 7'(MAX_BANDS)) n_eff = 7'(MAX_BANDS);
    else n_eff = band_count;
  end

  assign status.last = ({1'b0, idx_r} == (n_eff - 7'd1));

  assign ma = cmd.step[0] ? xi_r : xr_r;
  assign mb = (cmd.step == 4'd0 || cmd.step == 4'd3) ? hr_r : hi_r;
  assign mp = ma * mb;

  assign dd = $signed({1'b0, f_r}) - $signed({1'b0, c_r});
  assign ad = dd[20] ? 20'(-dd) : dd[19:0];

  assign ge = ({4'd0, rem_r} >= dv_r);

  assign coef = exp_coef(cmd.step);
  assign ep   = acc_r * coef;
  assign er   = ep + 64'h8000_0000;

  assign ga  = {1'b0, acc_r} + 33'h0000_8000;
  assign gs  = one_r ? 17'h1_0000 : ga[32:16];
  assign gq  = zero_r ? 16'd0 : (gs[16] ? 16'hFFFF : gs[15:0]);
  assign gsg = $signed({1'b0, g_r});
  assign pm  = (cmd.op == OP_MRE) ? pr_r * gsg : pi_r * gsg;

  function automatic logic signed [25:0] rnd_sat(input logic signed [57:0] p);
    logic signed [57:0] s;
    logic signed [27:0] q;
    s = p + 58'sd536870912;
    q = s[57:30];
    if (q > 28'sd33554431) return 26'sh1FFFFFF;
    if (q < -28'sd33554432) return 26'sh2000000;
    return q[25:0];
  endfunction

  always_ff @(posedge clk) begin
    if (capture) begin
      f_r   <= in_bin_freq;
      dc_r  <= in_dc_bin;
      hr_r  <= in_weight_re;
      hi_r  <= in_weight_im;
      xr_r  <= in_spec_re;
      xi_r  <= in_spec_im;
      idx_r <= 6'd0;
    end
    case (cmd.op)
      OP_PMUL: begin
        case (cmd.step)
          4'd0:    pr_r <= {mp[39], mp};
          4'd1:    pr_r <= pr_r - {mp[39], mp};
          4'd2:    pi_r <= {mp[39], mp};
          default: pi_r <= pi_r + {mp[39], mp};
        endcase
      end
      OP_DSQ: d2_r <= ad * ad;
      OP_WSQ: w2_r <= w_r * w_r;
      OP_CHK: begin
        // 0.5*r^2 of sixteen or more underflows the table
        zero_r <= (w_r == 20'd0) || ({5'd0, d2_r} >= {w2_r, 5'd0});
        rem_r  <= {d2_r, 7'd0};
        dv_r   <= {w2_r, 11'd0};
        x_r    <= 12'd0;
        one_r  <= 1'b1;
        acc_r  <= 32'd0;
      end
      OP_DIV: begin
        if (ge) rem_r <= rem_r - dv_r[46:0];
        x_r  <= {x_r[10:0], ge};
        dv_r <= dv_r >> 1;
      end
      OP_EXP: begin
        if (x_r[cmd.step]) begin
          one_r <= 1'b0;
          acc_r <= one_r ? coef : er[63:32];
        end
      end
      OP_GAIN: g_r   <= gq;
      OP_MRE:  pre_r <= pm;
      OP_MIM:  pim_r <= pm;
      OP_EMIT: idx_r <= idx_r + 6'd1;
      default: ;
    endcase
  end

  // result register, one beat per emit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= (cmd.op == OP_EMIT);
    end
    if (cmd.op == OP_EMIT) begin
      band_r <= idx_r;
      last_r <= status.last;
      re_r   <= dc_r ? 26'sd0 : rnd_sat(pre_r);
      im_r   <= dc_r ? 26'sd0 : rnd_sat(pim_r);
    end
  end

  assign out_strobe    = strobe_r;
  assign out_band      = band_r;
  assign out_re        = re_r;
  assign out_im        = im_r;
  assign out_last_band = last_r;

endmodule
`default_nettype wire

>>> src/gaussian_filterbank_bin_weighting_core.sv
// Top level of the Gaussian filter bank bin weighting block.
// A process beat gives one result per band in use, in band order; busy stays high
// until the last band is emitted, and no new beat is accepted while busy.
// Each band runs the 12-step divider and the 12-step exponent unit in turn.
// A load beat gives no result; results cannot be stalled.
// Synchronous active-low reset clears control and sets band_count to 1;
// the band table is not cleared.
`default_nettype none
`include "gaussian_filterbank_bin_weighting_core_defines.svh"
module gaussian_filterbank_bin_weighting_core
  import gfbw_pkg::*;
#(
  parameter int unsigned MAX_BANDS = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // command channel
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               in_action,
  input  wire logic [5:0]         in_band_slot,
  input  wire logic [19:0]        in_center_freq,
  input  wire logic [19:0]        in_band_width,
  input  wire logic [19:0]        in_bin_freq,
  input  wire logic               in_dc_bin,
  input  wire logic signed [15:0] in_weight_re,
  input  wire logic signed [15:0] in_weight_im,
  input  wire logic signed [23:0] in_spec_re,
  input  wire logic signed [23:0] in_spec_im,
  // result channel
  output logic                    out_strobe,
  output logic [5:0]              out_band,
  output logic signed [25:0]      out_re,
  output logic signed [25:0]      out_im,
  output logic                    out_last_band,
  // register port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  logic       accept;
  logic       go;
  logic       load_we;
  logic [6:0] band_count_r;
  cmd_t       cmd;
  status_t    status;

  // accept a beat whenever the sequencer is idle
  assign accept  = start && !busy;
  assign go      = accept && in_action;
  assign load_we = accept && !in_action;

  // band_count answers at addresses 0 to 3; addresses 4 to 7 drop writes and read zero
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_count_r <= 7'd1;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      band_count_r <= pwdata[6:0];
    end
  end
  assign prdata = paddr[2] ? 32'd0 : {25'd0, band_count_r};

  gfbw_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (go),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  gfbw_dp #(
    .MAX_BANDS (MAX_BANDS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .band_count     (band_count_r),
    .load_we        (load_we),
    .capture        (go),
    .in_band_slot   (in_band_slot),
    .in_center_freq (in_center_freq),
    .in_band_width  (in_band_width),
    .in_bin_freq    (in_bin_freq),
    .in_dc_bin      (in_dc_bin),
    .in_weight_re   (in_weight_re),
    .in_weight_im   (in_weight_im),
    .in_spec_re     (in_spec_re),
    .in_spec_im     (in_spec_im),
    .out_strobe     (out_strobe),
    .out_band       (out_band),
    .out_re         (out_re),
    .out_im         (out_im),
    .out_last_band  (out_last_band)
  );

  // final band releases the sequencer in the same beat
  `GFBW_ASSERT_IMPL(a_last_idle, clk, rst_n, out_strobe && out_last_band, !busy)
  // earlier bands keep the sequencer working
  `GFBW_ASSERT_IMPL(a_mid_busy, clk, rst_n, out_strobe && !out_last_band, busy)
  // result strobes never come back to back
  `GFBW_ASSERT_NEXT(a_spacing, clk, rst_n, out_strobe, !out_strobe)

endmodule
`default_nettype wire
